/* rtl/pli_pkg.sv */
// Shared types, widths and codes for the piecewise linear interpolator.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package pli_pkg;

    localparam int MAX_POINTS  = 16;
    localparam int VALUE_WIDTH = 16;

    // Widths fixed by the item and register formats.
    localparam int NP_W     = 5;
    localparam int PIDX_W   = 4;
    localparam int STATUS_W = 2;

    // Derived widths.
    localparam int IDX_W     = $clog2(MAX_POINTS);
    localparam int CNT_W     = $clog2(MAX_POINTS + 1);
    localparam int NCMP_W    = (CNT_W > NP_W) ? CNT_W : NP_W;
    localparam int PCMP_W    = (CNT_W > PIDX_W) ? CNT_W : PIDX_W;
    localparam int DW        = VALUE_WIDTH + 1;
    localparam int PROD_W    = 2 * VALUE_WIDTH;
    localparam int SUM_W     = PROD_W + 2;
    localparam int DIV_ITER  = PROD_W / 2;
    localparam int DIV_CNT_W = $clog2(DIV_ITER + 1);

    typedef enum logic [STATUS_W-1:0] {
        ST_LOADED = 2'd0,
        ST_OK     = 2'd1,
        ST_RANGE  = 2'd2,
        ST_BADSEG = 2'd3
    } status_t;

    typedef enum logic {
        KIND_LOAD  = 1'b0,
        KIND_QUERY = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        RD_LAST,
        RD_FIRST,
        RD_NEXT
    } rd_src_t;

    typedef enum logic [2:0] {
        RES_LOADED,
        RES_RANGE,
        RES_BADSEG,
        RES_HIT,
        RES_INTERP
    } res_sel_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHK_LAST,
        S_WALK,
        S_SEG,
        S_MUL,
        S_DIV,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic     rd_en;
        rd_src_t  rd_src;
        logic     walk_adv;
        logic     seg_load;
        logic     mul_en;
        logic     div_start;
        logic     set_res;
        res_sel_t res_sel;
        logic     out_load;
    } pli_cmd_t;

    typedef struct packed {
        logic n_zero;
        logic x_eq;
        logic x_lt;
        logic x_gt;
        logic idx_last;
        logic idx_zero;
        logic den_zero;
        logic div_done;
    } pli_stat_t;

    // Magnitude of a signed difference; the difference never reaches the
    // most negative code, so the magnitude fits VALUE_WIDTH bits.
    function automatic logic [VALUE_WIDTH-1:0] mag_f(input logic [DW-1:0] v);
        logic [DW-1:0] u;
        u = v[DW-1] ? (~v + {{(DW-1){1'b0}}, 1'b1}) : v;
        return u[VALUE_WIDTH-1:0];
    endfunction

endpackage

/* rtl/piecewise_linear_interpolator.sv */
// Piecewise linear interpolator, top level. A load request writes one
// breakpoint. A query request first checks the last breakpoint in use, then
// walks the table one entry per cycle from the first one (the single read
// port of the breakpoint tables sets this pace), then multiplies once and
// runs a divider that retires two quotient bits per cycle over a 32-bit
// product. One request is in work at a time; the finished result sits in an
// output register, so the next request is taken while it waits.
// Depends on pli_pkg, pli_ctrl and pli_datapath.
`timescale 1ns / 1ps

module piecewise_linear_interpolator import pli_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          kind,
    input  logic [PIDX_W-1:0]             point_index,
    input  logic signed [VALUE_WIDTH-1:0] x_value,
    input  logic signed [VALUE_WIDTH-1:0] y_value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [STATUS_W-1:0]           status,
    output logic signed [VALUE_WIDTH-1:0] y_result,
    input  logic                          cfg_we,
    input  logic [NP_W-1:0]               cfg_wdata
);

    pli_cmd_t  cmd;
    pli_stat_t stat;
    logic      in_accept;

    assign in_accept = in_valid && in_ready;

    pli_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    pli_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_accept   (in_accept),
        .kind        (kind),
        .point_index (point_index),
        .x_value     (x_value),
        .y_value     (y_value),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .cmd         (cmd),
        .stat        (stat),
        .status      (status),
        .y_result    (y_result)
    );

endmodule

/* rtl/pli_div.sv */
// Iterative unsigned restoring divider, two quotient bits per cycle.
// Depends on pli_pkg for widths.
`timescale 1ns / 1ps

module pli_div import pli_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [PROD_W-1:0]      dividend,
    input  logic [VALUE_WIDTH-1:0] divisor,
    output logic                   done,
    output logic [PROD_W-1:0]      quotient
);

    logic                   active_reg, active_next;
    logic                   done_reg, done_next;
    logic [DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [VALUE_WIDTH-1:0] rem_reg, rem_next;
    logic [PROD_W-1:0]      quo_reg, quo_next;
    logic [VALUE_WIDTH-1:0] div_reg;

    logic [VALUE_WIDTH-1:0] r_step;
    logic [PROD_W-1:0]      q_step;
    logic [VALUE_WIDTH:0]   trial;

    // Two dependent shift-compare-subtract steps; the dividend shifts out of
    // the top of the quotient register while quotient bits enter below.
    always_comb
    begin
        r_step = rem_reg;
        q_step = quo_reg;
        trial  = '0;
        for (int k = 0; k < 2; k++)
        begin
            trial  = {r_step, q_step[PROD_W-1]};
            q_step = {q_step[PROD_W-2:0], 1'b0};
            if (trial >= {1'b0, div_reg})
            begin
                trial     = trial - {1'b0, div_reg};
                q_step[0] = 1'b1;
            end
            r_step = trial[VALUE_WIDTH-1:0];
        end
    end

    always_comb
    begin
        active_next = active_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        if (start)
        begin
            active_next = 1'b1;
            cnt_next    = DIV_CNT_W'(DIV_ITER);
            rem_next    = '0;
            quo_next    = dividend;
        end
        else if (active_reg)
        begin
            rem_next = r_step;
            quo_next = q_step;
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            div_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* rtl/pli_datapath.sv */
// Datapath: breakpoint tables, table walk registers, segment arithmetic,
// result and output registers. Depends on pli_pkg and pli_div.
`timescale 1ns / 1ps

module pli_datapath import pli_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_accept,
    input  logic                          kind,
    input  logic [PIDX_W-1:0]             point_index,
    input  logic signed [VALUE_WIDTH-1:0] x_value,
    input  logic signed [VALUE_WIDTH-1:0] y_value,
    input  logic                          cfg_we,
    input  logic [NP_W-1:0]               cfg_wdata,
    input  pli_cmd_t                      cmd,
    output pli_stat_t                     stat,
    output logic [STATUS_W-1:0]           status,
    output logic signed [VALUE_WIDTH-1:0] y_result
);

    logic [VALUE_WIDTH-1:0] x_mem [MAX_POINTS];
    logic [VALUE_WIDTH-1:0] y_mem [MAX_POINTS];

    logic [NP_W-1:0]        num_points_reg;
    logic [CNT_W-1:0]       n_eff;
    logic [CNT_W-1:0]       n_m1;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [IDX_W-1:0]       rd_addr;
    logic [IDX_W-1:0]       wr_addr;
    logic                   wr_ok;

    logic [VALUE_WIDTH-1:0] qx_reg;
    logic [VALUE_WIDTH-1:0] rdx_reg, rdy_reg;
    logic [VALUE_WIDTH-1:0] prev_x_reg, prev_y_reg;

    logic [DW-1:0]          den_reg, dy_reg, dx_reg;
    logic [VALUE_WIDTH-1:0] yb_reg;
    logic                   neg_reg;
    logic [PROD_W-1:0]      prod_reg;

    logic [DW-1:0]          den_next, dy_next, dx_next;
    logic [VALUE_WIDTH-1:0] den_mag;

    logic                   div_done;
    logic [PROD_W-1:0]      quo;

    logic signed [SUM_W-1:0] q_signed, yb_ext, sum, lim_hi, lim_lo;
    logic [VALUE_WIDTH-1:0]  interp_y;

    status_t                res_status_reg, out_status_reg;
    logic [VALUE_WIDTH-1:0] res_y_reg, out_y_reg;

    // Effective point count is clamped to the table depth.
    always_comb
    begin
        if (NCMP_W'(num_points_reg) > NCMP_W'(MAX_POINTS))
        begin
            n_eff = CNT_W'(MAX_POINTS);
        end
        else
        begin
            n_eff = CNT_W'(num_points_reg);
        end
    end

    assign n_m1    = n_eff - CNT_W'(1);
    assign wr_ok   = PCMP_W'(point_index) < PCMP_W'(MAX_POINTS);
    assign wr_addr = IDX_W'(point_index);

    always_comb
    begin
        case (cmd.rd_src)
            RD_LAST:  rd_addr = IDX_W'(n_m1);
            RD_FIRST: rd_addr = '0;
            RD_NEXT:  rd_addr = idx_reg + IDX_W'(1);
            default:  rd_addr = '0;
        endcase
    end

    assign idx_next = (cmd.rd_en && cmd.rd_src != RD_LAST) ? rd_addr : idx_reg;

    // Table write on a load request; table read for the walk.
    always_ff @(posedge clk)
    begin
        if (in_accept && kind == KIND_LOAD && wr_ok)
        begin
            x_mem[wr_addr] <= x_value;
            y_mem[wr_addr] <= y_value;
        end
        if (cmd.rd_en)
        begin
            rdx_reg <= x_mem[rd_addr];
            rdy_reg <= y_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_points_reg <= '0;
        end
        else if (cfg_we)
        begin
            num_points_reg <= cfg_wdata;
        end
    end

    // Segment differences: b is the previous entry, a the current one.
    assign den_next = {rdx_reg[VALUE_WIDTH-1], rdx_reg}
                    - {prev_x_reg[VALUE_WIDTH-1], prev_x_reg};
    assign dy_next  = {rdy_reg[VALUE_WIDTH-1], rdy_reg}
                    - {prev_y_reg[VALUE_WIDTH-1], prev_y_reg};
    assign dx_next  = {qx_reg[VALUE_WIDTH-1], qx_reg}
                    - {prev_x_reg[VALUE_WIDTH-1], prev_x_reg};
    assign den_mag  = mag_f(den_reg);

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (in_accept)
        begin
            qx_reg <= x_value;
        end
        if (cmd.walk_adv)
        begin
            prev_x_reg <= rdx_reg;
            prev_y_reg <= rdy_reg;
        end
        if (cmd.seg_load)
        begin
            den_reg <= den_next;
            dy_reg  <= dy_next;
            dx_reg  <= dx_next;
            yb_reg  <= prev_y_reg;
            neg_reg <= dy_next[DW-1] ^ dx_next[DW-1] ^ den_next[DW-1];
        end
        if (cmd.mul_en)
        begin
            prod_reg <= mag_f(dy_reg) * mag_f(dx_reg);
        end
    end

    pli_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (prod_reg),
        .divisor  (den_mag),
        .done     (div_done),
        .quotient (quo)
    );

    // Apply the sign, add the base y and saturate to the value range.
    always_comb
    begin
        q_signed = neg_reg ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
        yb_ext   = SUM_W'($signed(yb_reg));
        sum      = yb_ext + q_signed;
        lim_hi   = SUM_W'((64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1);
        lim_lo   = -lim_hi - SUM_W'(1);
        if (sum > lim_hi)
        begin
            interp_y = lim_hi[VALUE_WIDTH-1:0];
        end
        else if (sum < lim_lo)
        begin
            interp_y = lim_lo[VALUE_WIDTH-1:0];
        end
        else
        begin
            interp_y = sum[VALUE_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.set_res)
        begin
            case (cmd.res_sel)
                RES_LOADED:
                begin
                    res_status_reg <= ST_LOADED;
                    res_y_reg      <= '0;
                end
                RES_RANGE:
                begin
                    res_status_reg <= ST_RANGE;
                    res_y_reg      <= '0;
                end
                RES_BADSEG:
                begin
                    res_status_reg <= ST_BADSEG;
                    res_y_reg      <= '0;
                end
                RES_HIT:
                begin
                    res_status_reg <= ST_OK;
                    res_y_reg      <= rdy_reg;
                end
                RES_INTERP:
                begin
                    res_status_reg <= ST_OK;
                    res_y_reg      <= interp_y;
                end
                default:
                begin
                    res_status_reg <= ST_RANGE;
                    res_y_reg      <= '0;
                end
            endcase
        end
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_y_reg      <= res_y_reg;
        end
    end

    always_comb
    begin
        stat.n_zero   = (n_eff == '0);
        stat.x_eq     = (qx_reg == rdx_reg);
        stat.x_lt     = ($signed(qx_reg) < $signed(rdx_reg));
        stat.x_gt     = ($signed(qx_reg) > $signed(rdx_reg));
        stat.idx_last = (idx_reg == IDX_W'(n_m1));
        stat.idx_zero = (idx_reg == '0);
        stat.den_zero = (den_reg == '0);
        stat.div_done = div_done;
    end

    assign status   = out_status_reg;
    assign y_result = out_y_reg;

endmodule

/* rtl/pli_ctrl.sv */
// Controller state machine: sequences the table walk, the multiply and the
// divide, and owns the request handshakes. Depends on pli_pkg.
`timescale 1ns / 1ps

module pli_ctrl import pli_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  logic      kind,
    output logic      out_valid,
    input  logic      out_ready,
    input  pli_stat_t stat,
    output pli_cmd_t  cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;
    logic   out_free;
    logic   walk_stop;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    // The walk ends below the current point or at the last point in use.
    assign walk_stop = stat.x_lt || stat.idx_last;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (kind == KIND_LOAD || stat.n_zero)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_CHK_LAST;
                    end
                end
            end
            S_CHK_LAST:
            begin
                state_next = stat.x_gt ? S_FINISH : S_WALK;
            end
            S_WALK:
            begin
                if (stat.x_eq)
                begin
                    state_next = S_FINISH;
                end
                else if (walk_stop)
                begin
                    state_next = stat.idx_zero ? S_FINISH : S_SEG;
                end
            end
            S_SEG:
            begin
                state_next = stat.den_zero ? S_FINISH : S_MUL;
            end
            S_MUL:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.rd_src  = RD_LAST;
        cmd.res_sel = RES_RANGE;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (kind == KIND_LOAD)
                    begin
                        cmd.set_res = 1'b1;
                        cmd.res_sel = RES_LOADED;
                    end
                    else if (stat.n_zero)
                    begin
                        cmd.set_res = 1'b1;
                        cmd.res_sel = RES_RANGE;
                    end
                    else
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_src = RD_LAST;
                    end
                end
            end
            S_CHK_LAST:
            begin
                if (stat.x_gt)
                begin
                    cmd.set_res = 1'b1;
                    cmd.res_sel = RES_RANGE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_src = RD_FIRST;
                end
            end
            S_WALK:
            begin
                if (stat.x_eq)
                begin
                    cmd.set_res = 1'b1;
                    cmd.res_sel = RES_HIT;
                end
                else if (walk_stop)
                begin
                    if (stat.idx_zero)
                    begin
                        cmd.set_res = 1'b1;
                        cmd.res_sel = RES_RANGE;
                    end
                    else
                    begin
                        cmd.seg_load = 1'b1;
                    end
                end
                else
                begin
                    cmd.walk_adv = 1'b1;
                    cmd.rd_en    = 1'b1;
                    cmd.rd_src   = RD_NEXT;
                end
            end
            S_SEG:
            begin
                if (stat.den_zero)
                begin
                    cmd.set_res = 1'b1;
                    cmd.res_sel = RES_BADSEG;
                end
                else
                begin
                    cmd.mul_en = 1'b1;
                end
            end
            S_MUL:
            begin
                cmd.div_start = 1'b1;
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.set_res = 1'b1;
                    cmd.res_sel = RES_INTERP;
                end
            end
            S_FINISH:
            begin
                cmd.out_load = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule
